// ===== src/psch_pkg.sv =====
package psch_pkg;

  localparam int ArrW   = 16;
  localparam int BurstW = 16;
  localparam int PriW   = 8;
  localparam int TickW  = 23;
  localparam int IdW    = 6;
  localparam int TotW   = 29;

  // One job as it sits in the job table.
  typedef struct packed {
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic [PriW-1:0]   prio;
  } job_t;

  // Controller state, one-hot.
  typedef enum logic [7:0] {
    S_LOAD     = 8'b0000_0001,
    S_SCAN     = 8'b0000_0010,
    S_DRAIN    = 8'b0000_0100,
    S_DECIDE   = 8'b0000_1000,
    S_OUT_RD   = 8'b0001_0000,
    S_OUT_DIFF = 8'b0010_0000,
    S_OUT_SUM  = 8'b0100_0000,
    S_OUT_HOLD = 8'b1000_0000
  } state_t;

  // Controls for the selection unit.
  typedef struct packed {
    logic clear;
    logic eval;
  } sel_ctl_t;

  // Controls for the result stage.
  typedef struct packed {
    logic diff;
    logic sum;
  } out_ctl_t;

endpackage

// ===== src/psch_if.sv =====
interface psch_in_if;
  import psch_pkg::*;

  logic              valid;
  logic              ready;
  logic [ArrW-1:0]   arr_tick;
  logic [BurstW-1:0] run_len;
  logic [PriW-1:0]   priority_req;
  logic              last;

  modport source (output valid, output arr_tick, output run_len,
                  output priority_req, output last, input ready);
  modport sink (input valid, input arr_tick, input run_len,
                input priority_req, input last, output ready);
endinterface

interface psch_out_if;
  import psch_pkg::*;

  logic             valid;
  logic             ready;
  logic [IdW-1:0]   job_id;
  logic [TickW-1:0] done_tick;
  logic [TickW-1:0] turnaround_time;
  logic [TickW-1:0] wait_len;
  logic [IdW-1:0]   dispatch_position;
  logic [TotW-1:0]  total_turnaround;
  logic [TotW-1:0]  total_waiting;
  logic             end_of_run;

  modport source (output valid, output job_id, output done_tick,
                  output turnaround_time, output wait_len,
                  output dispatch_position, output total_turnaround,
                  output total_waiting, output end_of_run, input ready);
  modport sink (input valid, input job_id, input done_tick,
                input turnaround_time, input wait_len,
                input dispatch_position, input total_turnaround,
                input total_waiting, input end_of_run, output ready);
endinterface

// ===== src/psch_select.sv =====
module psch_select #(
  parameter int IDXW = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  psch_pkg::sel_ctl_t      ctl,
  input  psch_pkg::job_t          job,
  input  logic [IDXW-1:0]         idx,
  input  logic                    finished,
  input  logic [psch_pkg::TickW-1:0] tick,
  output logic                    found,
  output logic [IDXW-1:0]         best_idx,
  output logic [psch_pkg::BurstW-1:0] best_burst,
  output logic [psch_pkg::ArrW-1:0]   min_arr
);
  import psch_pkg::*;

  logic [PriW-1:0] best_prio;
  logic            eligible;
  logic            better;

  // A job competes once it has arrived and is not yet done; a strictly
  // smaller priority is needed to displace the current pick, so the lower
  // index keeps a tie.
  assign eligible = !finished && (TickW'(job.arrival) <= tick);
  assign better   = eligible && (!found || (job.prio < best_prio));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.eval && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      min_arr <= '1;
    end else if (ctl.eval) begin
      if (better) begin
        best_idx   <= idx;
        best_prio  <= job.prio;
        best_burst <= job.burst;
      end
      if (!finished && (job.arrival < min_arr)) begin
        min_arr <= job.arrival;
      end
    end
  end

endmodule

// ===== src/psch_out.sv =====
module psch_out #(
  parameter int IDXW = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  psch_pkg::out_ctl_t         ctl,
  input  psch_pkg::job_t             job,
  input  logic [psch_pkg::TickW-1:0] comp,
  input  logic [IDXW-1:0]            pos,
  input  logic [IDXW-1:0]            idx,
  input  logic                       is_last,
  output logic                       sent,
  psch_out_if.source                 res
);
  import psch_pkg::*;

  logic [TickW-1:0] ta_q;
  logic [TickW-1:0] w_q;
  logic [TickW-1:0] comp_q;
  logic [IDXW-1:0]  pos_q;
  logic [IDXW-1:0]  idx_q;
  logic             last_q;
  logic [TickW-1:0] ta;
  logic             valid;
  logic [TotW-1:0]  tot_ta;
  logic [TotW-1:0]  tot_w;
  logic [TickW-1:0] o_comp;
  logic [TickW-1:0] o_ta;
  logic [TickW-1:0] o_w;
  logic [IDXW-1:0]  o_pos;
  logic [IDXW-1:0]  o_idx;
  logic             o_last;

  assign ta   = comp - TickW'(job.arrival);
  assign sent = valid && res.ready;

  // First stage: the two differences.
  always_ff @(posedge clk) begin
    if (ctl.diff) begin
      ta_q   <= ta;
      w_q    <= ta - TickW'(job.burst);
      comp_q <= comp;
      pos_q  <= pos;
      idx_q  <= idx;
      last_q <= is_last;
    end
  end

  // Second stage: running totals and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      tot_ta <= '0;
      tot_w  <= '0;
    end else if (ctl.sum) begin
      valid  <= 1'b1;
      tot_ta <= tot_ta + TotW'(ta_q);
      tot_w  <= tot_w + TotW'(w_q);
    end else if (sent) begin
      valid <= 1'b0;
      if (o_last) begin
        tot_ta <= '0;
        tot_w  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum) begin
      o_comp <= comp_q;
      o_ta   <= ta_q;
      o_w    <= w_q;
      o_pos  <= pos_q;
      o_idx  <= idx_q;
      o_last <= last_q;
    end
  end

  assign res.valid             = valid;
  assign res.job_id            = IdW'(o_idx);
  assign res.done_tick         = o_comp;
  assign res.turnaround_time   = o_ta;
  assign res.wait_len          = o_w;
  assign res.dispatch_position = IdW'(o_pos);
  assign res.total_turnaround  = tot_ta;
  assign res.total_waiting     = tot_w;
  assign res.end_of_run        = o_last;

endmodule

// ===== src/nonpreemptive_priority_scheduler_top.sv =====
// Non-preemptive priority scheduler. Jobs arrive one per transfer on in_job,
// each with an arrival tick, a burst length and a priority, and are written
// into a job table memory. The transfer with last set, or the one that fills
// the table (MAX_JOBS jobs), starts the schedule. Time starts at tick 0; each
// dispatch picks the arrived, unfinished job with the smallest priority value
// (lower index on a tie) and runs it to completion. Every dispatch is one pass
// over the job table through its single read port: N reads, a drain of the
// read latency and a commit. When nothing has arrived, the pass yields the
// earliest pending arrival, time jumps there and the pass repeats once. After
// the last dispatch, one result per job leaves on out_res in load order, each
// through a memory read, a difference stage, a totals stage and the transfer,
// which waits for out_res ready; the next result is read only after that
// transfer. No new job is taken until the last result of a set has been
// transferred.
module nonpreemptive_priority_scheduler_top #(
  parameter int MAX_JOBS = 64
) (
  input  logic       clk,
  input  logic       rst,
  psch_in_if.sink    in_job,
  psch_out_if.source out_res
);
  import psch_pkg::*;

  localparam int IDXW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNTW = $clog2(MAX_JOBS + 1);

  // Job table and result table, one synchronous read port each.
  job_t                   job_mem [MAX_JOBS];
  logic [TickW+IDXW-1:0]  res_mem [MAX_JOBS];
  job_t                   job_rd;
  logic [TickW+IDXW-1:0]  res_rd;

  state_t          state;
  logic [CNTW-1:0] job_count;
  logic [CNTW-1:0] cnt_m1;
  logic [IDXW-1:0] last_idx;
  logic [IDXW-1:0] idx;
  logic [IDXW-1:0] rd_idx_q;
  logic            rd_vld;
  logic [IDXW-1:0] disp;
  logic [TickW-1:0] tick;
  logic [TickW-1:0] tick_sum;
  logic [MAX_JOBS-1:0] finished;

  logic            in_xfer;
  logic            start;
  job_t            in_data;

  sel_ctl_t            sel_ctl;
  logic                found;
  logic [IDXW-1:0]     best_idx;
  logic [BurstW-1:0]   best_burst;
  logic [ArrW-1:0]     min_arr;

  out_ctl_t        out_ctl;
  logic            sent;

  assign in_job.ready = (state == S_LOAD);
  assign in_xfer      = in_job.valid && in_job.ready;
  assign start        = in_xfer && (in_job.last || (job_count == CNTW'(MAX_JOBS - 1)));

  assign in_data.arrival = in_job.arr_tick;
  assign in_data.burst   = in_job.run_len;
  assign in_data.prio    = in_job.priority_req;

  assign cnt_m1   = job_count - CNTW'(1);
  assign last_idx = cnt_m1[IDXW-1:0];
  assign tick_sum = tick + TickW'(best_burst);

  // Job table: written while loading, read at the scan/output index.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      job_mem[job_count[IDXW-1:0]] <= in_data;
    end
    job_rd <= job_mem[idx];
  end

  // Result table: completion tick and dispatch position of each job.
  always_ff @(posedge clk) begin
    if ((state == S_DECIDE) && found) begin
      res_mem[best_idx] <= {tick_sum, disp};
    end
    res_rd <= res_mem[idx];
  end

  // The read issued in one cycle is evaluated in the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_q <= idx;
  end

  assign sel_ctl.clear = start || (state == S_DECIDE);
  assign sel_ctl.eval  = rd_vld;

  psch_select #(
    .IDXW (IDXW)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .ctl        (sel_ctl),
    .job        (job_rd),
    .idx        (rd_idx_q),
    .finished   (finished[rd_idx_q]),
    .tick       (tick),
    .found      (found),
    .best_idx   (best_idx),
    .best_burst (best_burst),
    .min_arr    (min_arr)
  );

  assign out_ctl.diff = (state == S_OUT_DIFF);
  assign out_ctl.sum  = (state == S_OUT_SUM);

  psch_out #(
    .IDXW (IDXW)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .ctl     (out_ctl),
    .job     (job_rd),
    .comp    (res_rd[TickW+IDXW-1:IDXW]),
    .pos     (res_rd[IDXW-1:0]),
    .idx     (idx),
    .is_last (idx == last_idx),
    .sent    (sent),
    .res     (out_res)
  );

  // Sequencer: load, then repeated scan passes, then the result sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      job_count <= '0;
      idx       <= '0;
      disp      <= '0;
      tick      <= '0;
      finished  <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            job_count <= job_count + CNTW'(1);
            if (start) begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx == last_idx) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          idx <= '0;
          if (found) begin
            tick               <= tick_sum;
            finished[best_idx] <= 1'b1;
            if (disp == last_idx) begin
              disp  <= '0;
              state <= S_OUT_RD;
            end else begin
              disp  <= disp + IDXW'(1);
              state <= S_SCAN;
            end
          end else begin
            // Nothing ready: idle forward to the earliest pending arrival.
            tick  <= TickW'(min_arr);
            state <= S_SCAN;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_DIFF;
        end
        S_OUT_DIFF: begin
          state <= S_OUT_SUM;
        end
        S_OUT_SUM: begin
          state <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (sent) begin
            if (idx == last_idx) begin
              job_count <= '0;
              tick      <= '0;
              finished  <= '0;
              idx       <= '0;
              state     <= S_LOAD;
            end else begin
              idx   <= idx + IDXW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result is offered only while the sequencer waits for its transfer.
  a_valid_in_hold: assert property (@(posedge clk) disable iff (rst)
    out_res.valid |-> (state == S_OUT_HOLD))
    else $error("result valid outside the hold state");

  // A dispatch never picks a job that has already run.
  a_pick_unfinished: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DECIDE) && found) |-> !finished[best_idx])
    else $error("dispatch of a finished job");

  // Time never moves backward within a run.
  a_tick_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |=> (tick >= $past(tick)))
    else $error("tick moved backward");

  // A scan pass only runs over a non-empty job set.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (job_count != '0))
    else $error("scan with an empty job table");
`endif

endmodule
